// ----- design/rpp_pkg.sv -----
package rpp_pkg;

  // register indexes of the configuration port
  typedef enum logic [1:0] {
    REG_WIDGET_LEFT = 2'd0,
    REG_WIDGET_TOP  = 2'd1,
    REG_WIDGET_SIZE = 2'd2,
    REG_ZOOM_RANGE  = 2'd3
  } reg_idx_t;

  localparam int CORDIC_ITERS = 16;
  localparam int CORDIC_START = 652032874;   // 1/K in Q30
  localparam int PLOT_MARGIN  = 7;
  localparam int IN_W         = 16;
  localparam int OUT_W        = 13;
  localparam int SIZE_W       = 11;
  localparam int POS_W        = 12;
  localparam int QUOT_W       = 11;          // |offset| <= widget size

  // arctangent of 2^-i in heading codes, rounded
  localparam logic [13:0] ATAN_CODES [CORDIC_ITERS] = '{
    14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163, 14'd81,
    14'd41, 14'd20, 14'd10, 14'd5, 14'd3, 14'd1, 14'd1, 14'd0
  };

  // sign of each axis offset
  typedef struct packed {
    logic neg_x;
    logic neg_y;
  } sgn_t;

endpackage

// ----- design/rpp_cordic.sv -----
module rpp_cordic #(
  parameter int F     = 15,
  parameter int TAG_W = 34
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [15:0]         in_code,
  input  logic [TAG_W-1:0]    in_tag,
  output logic                out_valid,
  output logic signed [F+2:0] out_sin,
  output logic signed [F+2:0] out_cos,
  output logic [TAG_W-1:0]    out_tag
);

  localparam int N   = rpp_pkg::CORDIC_ITERS;
  localparam int XW  = 33;
  localparam int ZW  = 18;
  localparam int SCW = F + 3;

  logic signed [XW-1:0] x_r [N+1];
  logic signed [XW-1:0] y_r [N+1];
  logic signed [ZW-1:0] z_r [N+1];
  logic [TAG_W-1:0]     tag_r [N+1];
  logic                 neg_r [N+1];
  logic                 v_r   [N+1];

  logic signed [SCW-1:0] sin_r, cos_r;
  logic [TAG_W-1:0]      otag_r;
  logic                  ov_r;

  // headings in the back half are turned by a half turn, result negated
  logic        flip;
  logic [15:0] code_n;
  assign flip   = (in_code >= 16'd16384) && (in_code < 16'd49152);
  assign code_n = flip ? (in_code + 16'd32768) : in_code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
    if (en) begin
      x_r[0]   <= XW'(rpp_pkg::CORDIC_START);
      y_r[0]   <= '0;
      z_r[0]   <= ZW'($signed(code_n));
      neg_r[0] <= flip;
      tag_r[0] <= in_tag;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] a;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    assign a  = $signed({{(ZW-14){1'b0}}, rpp_pkg::ATAN_CODES[i]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
      if (en) begin
        if (!z_r[i][ZW-1]) begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - a;
        end else begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + a;
        end
        neg_r[i+1] <= neg_r[i];
        tag_r[i+1] <= tag_r[i];
      end
    end
  end

  // round half up from Q30 to Q(F)
  localparam logic signed [XW-1:0] HALF = XW'(1) <<< (29 - F);
  logic signed [XW-1:0] xr, yr;
  logic signed [SCW-1:0] xq, yq;
  assign xr = (x_r[N] + HALF) >>> (30 - F);
  assign yr = (y_r[N] + HALF) >>> (30 - F);
  assign xq = xr[SCW-1:0];
  assign yq = yr[SCW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= v_r[N];
    end
    if (en) begin
      cos_r  <= neg_r[N] ? -xq : xq;
      sin_r  <= neg_r[N] ? -yq : yq;
      otag_r <= tag_r[N];
    end
  end

  assign out_valid = ov_r;
  assign out_sin   = sin_r;
  assign out_cos   = cos_r;
  assign out_tag   = otag_r;

endmodule

// ----- design/rpp_divider.sv -----
module rpp_divider #(
  parameter int NW = 47,
  parameter int DW = 36,
  parameter int QW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num_x,
  input  logic [NW-1:0] in_num_y,
  input  logic [DW-1:0] in_den,
  input  rpp_pkg::sgn_t in_sgn,
  output logic          out_valid,
  output logic [QW-1:0] out_qx,
  output logic [QW-1:0] out_qy,
  output rpp_pkg::sgn_t out_sgn
);

  logic [NW-1:0]       rx_r  [QW+1];
  logic [NW-1:0]       ry_r  [QW+1];
  logic [QW-1:0]       qx_r  [QW+1];
  logic [QW-1:0]       qy_r  [QW+1];
  logic [DW-1:0]       den_r [QW+1];
  rpp_pkg::sgn_t       sgn_r [QW+1];
  logic                v_r   [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
    if (en) begin
      rx_r[0]  <= in_num_x;
      ry_r[0]  <= in_num_y;
      qx_r[0]  <= '0;
      qy_r[0]  <= '0;
      den_r[0] <= in_den;
      sgn_r[0] <= in_sgn;
    end
  end

  // restoring division, one quotient bit per stage, MSB first
  for (genvar k = 0; k < QW; k++) begin : g_bit
    localparam int B = QW - 1 - k;
    logic [NW-1:0] trial;
    logic          hx, hy;
    logic [QW-1:0] qxn, qyn;
    assign trial = NW'(den_r[k]) << B;
    assign hx    = rx_r[k] >= trial;
    assign hy    = ry_r[k] >= trial;
    assign qxn   = qx_r[k] | (QW'(hx) << B);
    assign qyn   = qy_r[k] | (QW'(hy) << B);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
      if (en) begin
        rx_r[k+1]  <= hx ? rx_r[k] - trial : rx_r[k];
        ry_r[k+1]  <= hy ? ry_r[k] - trial : ry_r[k];
        qx_r[k+1]  <= qxn;
        qy_r[k+1]  <= qyn;
        den_r[k+1] <= den_r[k];
        sgn_r[k+1] <= sgn_r[k];
      end
    end
  end

  logic dz;
  assign dz        = den_r[QW] == '0;
  assign out_valid = v_r[QW];
  assign out_qx    = dz ? '0 : qx_r[QW];
  assign out_qy    = dz ? '0 : qy_r[QW];
  assign out_sgn   = sgn_r[QW];

endmodule

// ----- design/radar_point_projection.sv -----
// Channel  Dir  Signals                                         Transfer when
// in       in   in_target_x/y, in_eye_x/y, in_heading (16 b)    in_valid & in_ready
// out      out  out_screen_x, out_screen_y (13 b)               out_valid & out_ready
// cfg      in   cfg_index (2 b), cfg_data (16 b)                cfg_valid & cfg_ready
//
// One point per cycle sustained unless the output stalls. From input transfer
// to out_valid: 18 CORDIC, 5 multiply/select, 12 divide, 1 output register.
// Reset is synchronous, rst_n low; clears valid bits and loads register
// defaults. cfg_ready is always high.
// A stalled output parks one result in a skid register; only then does
// in_ready drop and the whole pipeline hold.
module radar_point_projection #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_target_x,
  input  logic [15:0] in_target_y,
  input  logic [15:0] in_eye_x,
  input  logic [15:0] in_eye_y,
  input  logic [15:0] in_heading,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [12:0] out_screen_x,
  output logic [12:0] out_screen_y,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int F   = TRIG_FRAC_BITS;
  localparam int SCW = F + 3;        // sin/cos width
  localparam int PW  = 17 + SCW;     // product width
  localparam int MW  = PW + 1;       // rotated coordinate width
  localparam int RW  = 16 + F;       // range << F
  localparam int QW  = rpp_pkg::QUOT_W;
  localparam int NW  = MW + QW;      // dividend width
  localparam int LW  = 18;           // low partial product split
  localparam int HW  = MW - LW;

  // ---------------- configuration registers ----------------
  logic [11:0] left_r, top_r;
  logic [10:0] size_r;
  logic [15:0] range_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= '0;
      top_r   <= '0;
      size_r  <= 11'd150;
      range_r <= 16'd1000;
    end else if (cfg_valid) begin
      case (rpp_pkg::reg_idx_t'(cfg_index))
        rpp_pkg::REG_WIDGET_LEFT: left_r  <= cfg_data[11:0];
        rpp_pkg::REG_WIDGET_TOP:  top_r   <= cfg_data[11:0];
        rpp_pkg::REG_WIDGET_SIZE: size_r  <= cfg_data[10:0];
        rpp_pkg::REG_ZOOM_RANGE:  range_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: pipeline moves unless the skid register is occupied
  logic skid_v_r, adv;
  assign adv      = !skid_v_r;
  assign in_ready = adv;

  // ---------------- offset and sin/cos ----------------
  logic signed [16:0] dx_in, dy_in;
  assign dx_in = 17'($signed(in_target_x)) - 17'($signed(in_eye_x));
  assign dy_in = 17'($signed(in_target_y)) - 17'($signed(in_eye_y));

  logic                  c_v;
  logic signed [SCW-1:0] c_sin, c_cos;
  logic [33:0]           c_tag;

  rpp_cordic #(.F(F), .TAG_W(34)) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_valid),
    .in_code  (in_heading),
    .in_tag   ({dx_in, dy_in}),
    .out_valid(c_v),
    .out_sin  (c_sin),
    .out_cos  (c_cos),
    .out_tag  (c_tag)
  );

  logic signed [16:0] c_dx, c_dy;
  assign c_dx = $signed(c_tag[33:17]);
  assign c_dy = $signed(c_tag[16:0]);

  // ---------------- rotation products ----------------
  logic                 a_v_r;
  logic signed [PW-1:0] p1_r, p2_r, p3_r, p4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (adv) a_v_r <= c_v;
    if (adv) begin
      p1_r <= PW'(c_dx) * PW'(c_sin);
      p2_r <= PW'(c_dy) * PW'(c_cos);
      p3_r <= PW'(c_dx) * PW'(c_cos);
      p4_r <= PW'(c_dy) * PW'(c_sin);
    end
  end

  // x = dx*sin - dy*cos, y = -dx*cos - dy*sin
  logic                 b_v_r;
  logic signed [MW-1:0] xq_r, yq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else if (adv) b_v_r <= a_v_r;
    if (adv) begin
      xq_r <= MW'(p1_r) - MW'(p2_r);
      yq_r <= -MW'(p3_r) - MW'(p4_r);
    end
  end

  // ---------------- border test and divisor choice ----------------
  // Off the zoom square the larger coordinate is the divisor and pins
  // itself to +-size; inside, both axes divide by range << F.
  logic [MW-1:0] ax, ay, rq;
  logic [15:0]   range_eff;
  logic          border, by_y;
  assign ax        = xq_r[MW-1] ? MW'(-xq_r) : MW'(xq_r);
  assign ay        = yq_r[MW-1] ? MW'(-yq_r) : MW'(yq_r);
  assign range_eff = (range_r == '0) ? 16'd1 : range_r;
  assign rq        = MW'({range_eff, {F{1'b0}}});
  assign border    = (ax > rq) || (ay > rq);
  assign by_y      = (yq_r > xq_r) == (yq_r > -xq_r);

  logic          d_v_r;
  logic [MW-1:0] ax_r, ay_r, den_d_r;
  rpp_pkg::sgn_t sgn_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d_v_r <= 1'b0;
    else if (adv) d_v_r <= b_v_r;
    if (adv) begin
      ax_r    <= ax;
      ay_r    <= ay;
      den_d_r <= border ? (by_y ? ay : ax) : rq;
      sgn_d_r <= '{neg_x: xq_r[MW-1], neg_y: yq_r[MW-1]};
    end
  end

  // ---------------- |v| * size, split in two partial products ----------------
  logic              e_v_r;
  logic [LW+10:0]    plx_r, ply_r;
  logic [HW+10:0]    phx_r, phy_r;
  logic [MW-1:0]     den_e_r;
  rpp_pkg::sgn_t     sgn_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) e_v_r <= 1'b0;
    else if (adv) e_v_r <= d_v_r;
    if (adv) begin
      plx_r   <= (LW+11)'(ax_r[LW-1:0]) * (LW+11)'(size_r);
      ply_r   <= (LW+11)'(ay_r[LW-1:0]) * (LW+11)'(size_r);
      phx_r   <= (HW+11)'(ax_r[MW-1:LW]) * (HW+11)'(size_r);
      phy_r   <= (HW+11)'(ay_r[MW-1:LW]) * (HW+11)'(size_r);
      den_e_r <= den_d_r;
      sgn_e_r <= sgn_d_r;
    end
  end

  logic              f_v_r;
  logic [NW-1:0]     nx_r, ny_r;
  logic [MW-1:0]     den_f_r;
  rpp_pkg::sgn_t     sgn_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) f_v_r <= 1'b0;
    else if (adv) f_v_r <= e_v_r;
    if (adv) begin
      nx_r    <= (NW'(phx_r) << LW) + NW'(plx_r);
      ny_r    <= (NW'(phy_r) << LW) + NW'(ply_r);
      den_f_r <= den_e_r;
      sgn_f_r <= sgn_e_r;
    end
  end

  // ---------------- division ----------------
  logic          q_v;
  logic [QW-1:0] qx, qy;
  rpp_pkg::sgn_t q_sgn;

  rpp_divider #(.NW(NW), .DW(MW), .QW(QW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (f_v_r),
    .in_num_x (nx_r),
    .in_num_y (ny_r),
    .in_den   (den_f_r),
    .in_sgn   (sgn_f_r),
    .out_valid(q_v),
    .out_qx   (qx),
    .out_qy   (qy),
    .out_sgn  (q_sgn)
  );

  // ---------------- offset to widget and clamp ----------------
  // Upper clamp first; below the corner lands one pixel inside it.
  logic signed [14:0] ox, oy, half, sx, sy, hx, hy, lx, ly, cx, cy;
  always_comb begin
    ox   = q_sgn.neg_x ? -15'($signed({1'b0, qx})) : 15'($signed({1'b0, qx}));
    oy   = q_sgn.neg_y ? -15'($signed({1'b0, qy})) : 15'($signed({1'b0, qy}));
    half = 15'($signed({1'b0, size_r[10:1]}));
    lx   = 15'($signed({1'b0, left_r}));
    ly   = 15'($signed({1'b0, top_r}));
    sx   = lx + half + ox;
    sy   = ly + half + oy;
    hx   = 15'($signed({1'b0, size_r})) + lx - 15'(rpp_pkg::PLOT_MARGIN);
    hy   = 15'($signed({1'b0, size_r})) + ly - 15'(rpp_pkg::PLOT_MARGIN);
    cx   = (sx > hx) ? hx : sx;
    cy   = (sy > hy) ? hy : sy;
    if (cx < lx) cx = lx + 15'sd1;
    if (cy < ly) cy = ly + 15'sd1;
  end

  // ---------------- output register and skid ----------------
  logic        out_v_r;
  logic [12:0] ox_r, oy_r, kx_r, ky_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ready) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end
    end else if (out_v_r && !out_ready) begin
      skid_v_r <= q_v;
    end else begin
      out_v_r <= q_v;
    end
    if (skid_v_r) begin
      if (out_ready) begin
        ox_r <= kx_r;
        oy_r <= ky_r;
      end
    end else if (out_v_r && !out_ready) begin
      kx_r <= cx[12:0];
      ky_r <= cy[12:0];
    end else begin
      ox_r <= cx[12:0];
      oy_r <= cy[12:0];
    end
  end

  assign out_valid    = out_v_r;
  assign out_screen_x = ox_r;
  assign out_screen_y = oy_r;

  // skid holds a result only behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid occupied with empty output register");

  // a parked result is never dropped while the sink stalls
  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_ready) |=> (skid_v_r && $stable(kx_r) && $stable(ky_r)))
    else $error("skid result lost under stall");

  // draining the skid refills the output register
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_ready) |=> (out_v_r && !skid_v_r))
    else $error("skid drain failed");

endmodule
